FILE: hw/rtl/epf_pkg.sv
// package for the eeg p2 packet framer: packet byte codes, switch phase
// constants, multiplier widths, byte escaping and sample shaping functions
// no dependencies
`default_nettype none

package epf_pkg;

  localparam logic [7:0] SyncA    = 8'hA5;
  localparam logic [7:0] SyncB    = 8'h5A;
  localparam logic [7:0] ProtoVer = 8'h02;
  localparam logic [7:0] EscByte  = 8'hA4;
  localparam logic [7:0] SwLow    = 8'h07;
  localparam logic [7:0] SwHigh   = 8'h0F;

  localparam int unsigned MaxChannels = 6;
  localparam int unsigned SampleW     = 24;
  localparam int unsigned ShapeW      = 10;

  localparam logic [4:0] PhaseLast = 5'd17;
  localparam logic [4:0] PhaseHigh = 5'd9;

  // shared multiplier operand widths
  localparam int unsigned MulAW = 21;
  localparam int unsigned MulBW = 14;
  localparam int unsigned MulPW = MulAW + MulBW;

  // ramp generator constants
  localparam int unsigned RampW = 14;
  localparam logic [8:0]       RampMid   = 9'd127;
  localparam logic [MulBW-1:0] RampAmp   = 14'd8950;
  localparam logic [MulBW-1:0] RampRecip = 14'd257;
  localparam logic [MulBW-1:0] RampDiv   = 14'd255;
  localparam logic signed [RampW-1:0] RampOfs = 14'sd639;

  function automatic logic [7:0] esc(input logic [7:0] b);
    esc = (b == SyncA) ? EscByte : b;
  endfunction

  // divide by 32 toward zero, then cap: negative nonzero and large go to 1023
  function automatic logic [ShapeW-1:0] shape(input logic signed [SampleW-1:0] v);
    if (!v[SampleW-1]) begin
      shape = (|v[SampleW-2:15]) ? '1 : v[14:5];
    end else begin
      shape = ((&v[SampleW-2:5]) && (|v[4:0])) ? '0 : '1;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/epf_mul.sv
// shared unsigned multiplier with registered product
// depends on epf_pkg for operand widths
`default_nettype none

module epf_mul import epf_pkg::*; (
  input  logic             clk_i,
  input  logic [MulAW-1:0] a_i,
  input  logic [MulBW-1:0] b_i,
  output logic [MulPW-1:0] p_o
);

  logic [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: hw/rtl/eeg_p2_packet_framer.sv
// Packet framer: one frame request in, one packet of 5 + 2*NUM_CHANNELS bytes
// out, one byte per output transaction. The request is taken only while the
// framer is idle. In synthetic mode each channel first runs the ramp states:
// four passes through the single shared multiplier that builds the ramp value,
// then its final correction. Output back-pressure holds the framer in its
// current byte state. Depends on epf_pkg and epf_mul.
`default_nettype none

module eeg_p2_packet_framer import epf_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 frame_count_i,
  input  logic signed [SampleW-1:0]  chan_a_i,
  input  logic signed [SampleW-1:0]  chan_b_i,
  input  logic signed [SampleW-1:0]  chan_c_i,
  input  logic signed [SampleW-1:0]  chan_d_i,
  input  logic signed [SampleW-1:0]  chan_e_i,
  input  logic signed [SampleW-1:0]  chan_f_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_byte_o
);

  localparam int unsigned ChW = $clog2(MaxChannels);
  localparam logic [ChW-1:0] LastCh = ChW'(NUM_CHANNELS - 1);

  typedef enum logic [3:0] {
    StIdle, StSyncA, StSyncB, StVer, StCount,
    StRamp1, StRamp2, StRamp3, StRamp4, StRamp5,
    StHi, StLo, StSwitch
  } state_e;

  state_e state_q, state_d;
  logic [ChW-1:0] ch_q, ch_d;
  logic synth_q, synth_d;
  logic [4:0] phase_q, phase_d;
  logic out_vld_q, out_vld_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic out_last_q, out_last_d;

  // payload registers
  logic [7:0] count_q;
  logic signed [SampleW-1:0] chan_q [MaxChannels];
  logic neg_q, neg_d;
  logic [MulAW-1:0] x_q, x_d;
  logic [12:0] q0_q, q0_d;
  logic signed [RampW-1:0] ramp_q, ramp_d;
  logic [7:0] lo_q, lo_d;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] prod;

  logic out_free, accept;
  logic signed [8:0] r9;
  logic [7:0] mag;
  logic [MulAW-1:0] rem;
  logic [12:0] qv;
  logic signed [RampW-1:0] sv;
  logic signed [SampleW-1:0] src;
  logic [ShapeW-1:0] u;
  logic [4:0] phase_nx;

  epf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign out_free = !out_vld_q || out_ready_i;
  assign accept   = (state_q == StIdle) && in_valid_i;

  assign r9  = $signed({1'b0, prod[7:0]}) - $signed(RampMid);
  assign mag = r9[8] ? 8'(-r9) : r9[7:0];
  assign rem = x_q - prod[MulAW-1:0];
  assign qv  = q0_q + 13'(rem >= MulAW'(RampDiv));
  assign sv  = neg_q ? -$signed({1'b0, qv}) : $signed({1'b0, qv});

  assign src = synth_q ? {{(SampleW-RampW){ramp_q[RampW-1]}}, ramp_q} : chan_q[ch_q];
  assign u   = shape(src);

  assign phase_nx = (phase_q >= PhaseLast) ? 5'd0 : phase_q + 5'd1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StRamp1: begin
        mul_a = MulAW'(count_q);
        mul_b = MulBW'(ch_q) + MulBW'(1);
      end
      StRamp2: begin
        mul_a = MulAW'(mag);
        mul_b = RampAmp;
      end
      StRamp3: begin
        mul_a = prod[MulAW-1:0];
        mul_b = RampRecip;
      end
      StRamp4: begin
        mul_a = MulAW'(prod[28:16]);
        mul_b = RampDiv;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    phase_d    = phase_q;
    synth_d    = cfg_we_i ? cfg_wdata_i : synth_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    neg_d      = neg_q;
    x_d        = x_q;
    q0_d       = q0_q;
    ramp_d     = ramp_q;
    lo_d       = lo_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StSyncA;
        end
      end
      StSyncA, StSyncB, StVer: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_last_d = 1'b0;
          case (state_q)
            StSyncA: begin
              out_byte_d = SyncA;
              state_d    = StSyncB;
            end
            StSyncB: begin
              out_byte_d = SyncB;
              state_d    = StVer;
            end
            default: begin
              out_byte_d = ProtoVer;
              state_d    = StCount;
            end
          endcase
        end
      end
      StCount: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_last_d = 1'b0;
          out_byte_d = esc(count_q);
          ch_d       = '0;
          state_d    = synth_q ? StRamp1 : StHi;
        end
      end
      StRamp1: state_d = StRamp2;
      StRamp2: begin
        neg_d   = r9[8];
        state_d = StRamp3;
      end
      StRamp3: begin
        x_d     = prod[MulAW-1:0];
        state_d = StRamp4;
      end
      StRamp4: begin
        q0_d    = prod[28:16];
        state_d = StRamp5;
      end
      StRamp5: begin
        ramp_d  = sv + RampOfs;
        state_d = StHi;
      end
      StHi: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_last_d = 1'b0;
          out_byte_d = {6'b0, u[ShapeW-1:8]};
          lo_d       = esc(u[7:0]);
          state_d    = StLo;
        end
      end
      StLo: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_last_d = 1'b0;
          out_byte_d = lo_q;
          if (ch_q == LastCh) begin
            state_d = StSwitch;
          end else begin
            ch_d    = ch_q + ChW'(1);
            state_d = synth_q ? StRamp1 : StHi;
          end
        end
      end
      StSwitch: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          out_byte_d = (phase_nx >= PhaseHigh) ? SwHigh : SwLow;
          phase_d    = phase_nx;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      ch_q       <= '0;
      synth_q    <= 1'b0;
      phase_q    <= PhaseLast;
      out_vld_q  <= 1'b0;
      out_byte_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ch_q       <= ch_d;
      synth_q    <= synth_d;
      phase_q    <= phase_d;
      out_vld_q  <= out_vld_d;
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      count_q   <= frame_count_i;
      chan_q[0] <= chan_a_i;
      chan_q[1] <= chan_b_i;
      chan_q[2] <= chan_c_i;
      chan_q[3] <= chan_d_i;
      chan_q[4] <= chan_e_i;
      chan_q[5] <= chan_f_i;
    end
    neg_q  <= neg_d;
    x_q    <= x_d;
    q0_q   <= q0_d;
    ramp_q <= ramp_d;
    lo_q   <= lo_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/epf_checker.sv
// port-level checks for the eeg p2 packet framer, bound to the top level
// depends on epf_pkg and eeg_p2_packet_framer
`default_nettype none

module epf_checker import epf_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_byte_o
);

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_byte_o) && $stable(last_byte_o)))
    else $error("output transaction changed while stalled");

  // framer goes busy after taking a frame request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("framer still ready after accepting a frame");

  // packet ends on a switch byte
  a_last_is_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_byte_o) |-> (out_byte_o == SwLow || out_byte_o == SwHigh))
    else $error("last byte is not a switch byte");

endmodule

bind eeg_p2_packet_framer epf_checker u_epf_checker (.*);

`default_nettype wire
